### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks, reduced to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/apda_pkg.sv
// ----------------------------------------------------------------------------
// apda_pkg
// Types and fixed constants of the audio presence detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apda_pkg;

    localparam int NUM_BANDS     = 4;
    localparam int BAND_BITS     = 2;
    localparam int WIN_REG_BITS  = 7;
    localparam int THR_BITS      = 11;
    localparam int HOLD_BITS     = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int SRC_BITS      = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_A  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_B  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_C  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_D  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 3'd5;

    localparam logic [WIN_REG_BITS-1:0] WINDOW_RESET = 7'd1;
    localparam logic [THR_BITS-1:0]     THR_RESET    = 11'd64;
    localparam logic [HOLD_BITS-1:0]    HOLD_RESET   = 16'd1024;

    // result word layout, lowest bit first
    localparam int OUT_ACTIVE_BIT = 0;
    localparam int OUT_SRC_OK_BIT = 1;
    localparam int OUT_SRC_LSB    = 2;
    localparam int OUT_RISE_BIT   = 4;
    localparam int OUT_FALL_BIT   = 5;
    localparam int OUT_AVG_LSB    = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_AVG,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [NUM_BANDS-1:0][WIN_REG_BITS-1:0] window;
        logic [THR_BITS-1:0]                    threshold;
        logic [HOLD_BITS-1:0]                   hold;
    } t_cfg;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic rd;
        logic upd;
        logic div_step;
        logic avg_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic det_hit;
        logic div_last;
        logic last_band;
    } t_stat;

endpackage

`default_nettype wire

### rtl/apda_cfg.sv
// ----------------------------------------------------------------------------
// apda_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apda_cfg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [apda_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [apda_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output apda_pkg::t_cfg                      o_cfg
);

    apda_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < apda_pkg::NUM_BANDS; b++) begin
                r_cfg.window[b] <= apda_pkg::WINDOW_RESET;
            end
            r_cfg.threshold <= apda_pkg::THR_RESET;
            r_cfg.hold      <= apda_pkg::HOLD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                apda_pkg::CFG_WINDOW_A: begin
                    r_cfg.window[0] <= i_cfg_wdata[apda_pkg::WIN_REG_BITS-1:0];
                end
                apda_pkg::CFG_WINDOW_B: begin
                    r_cfg.window[1] <= i_cfg_wdata[apda_pkg::WIN_REG_BITS-1:0];
                end
                apda_pkg::CFG_WINDOW_C: begin
                    r_cfg.window[2] <= i_cfg_wdata[apda_pkg::WIN_REG_BITS-1:0];
                end
                apda_pkg::CFG_WINDOW_D: begin
                    r_cfg.window[3] <= i_cfg_wdata[apda_pkg::WIN_REG_BITS-1:0];
                end
                apda_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_wdata[apda_pkg::THR_BITS-1:0];
                end
                apda_pkg::CFG_HOLD: begin
                    r_cfg.hold <= i_cfg_wdata[apda_pkg::HOLD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/apda_ctrl.sv
// ----------------------------------------------------------------------------
// apda_ctrl
// Sequencer: store clearing, word intake, per-window update, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apda_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  wire             i_m_tready,
    input  apda_pkg::t_stat i_stat,
    output apda_pkg::t_cmd  o_cmd
);

    apda_pkg::t_state r_state;
    apda_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apda_pkg::ST_CLEAR: begin
                if (i_stat.clr_done) n_state = apda_pkg::ST_IDLE;
            end
            apda_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_stat.det_hit ? apda_pkg::ST_READ : apda_pkg::ST_DONE;
                end
            end
            apda_pkg::ST_READ: begin
                n_state = apda_pkg::ST_UPDATE;
            end
            apda_pkg::ST_UPDATE: begin
                n_state = apda_pkg::ST_DIV;
            end
            apda_pkg::ST_DIV: begin
                if (i_stat.div_last) n_state = apda_pkg::ST_AVG;
            end
            apda_pkg::ST_AVG: begin
                n_state = i_stat.last_band ? apda_pkg::ST_DONE : apda_pkg::ST_READ;
            end
            apda_pkg::ST_DONE: begin
                if (out_free) n_state = apda_pkg::ST_IDLE;
            end
            default: begin
                n_state = apda_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            apda_pkg::ST_CLEAR: begin
                o_cmd.clr_en = !i_stat.clr_done;
            end
            apda_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            apda_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            apda_pkg::ST_UPDATE: begin
                o_cmd.upd = 1'b1;
            end
            apda_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            apda_pkg::ST_AVG: begin
                o_cmd.avg_wr = 1'b1;
            end
            apda_pkg::ST_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apda_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

### rtl/apda_dp.sv
// ----------------------------------------------------------------------------
// apda_dp
// Datapath: difference detector, hold logic, window store, serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apda_dp #(
    parameter int NUM_CHANNELS = 4,
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_BITS  = 10,
    localparam int IN_BITS  = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS =
        ((apda_pkg::OUT_AVG_LSB + apda_pkg::NUM_BANDS * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  apda_pkg::t_cfg      i_cfg,
    input  apda_pkg::t_cmd      i_cmd,
    output apda_pkg::t_stat     o_stat,
    input  wire  [IN_BITS-1:0]  i_s_tdata,
    output logic [OUT_BITS-1:0] o_m_tdata
);

    localparam int CH_BITS   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_BITS  = $clog2(MAX_WINDOW);
    localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + POS_BITS;
    localparam int CNT_BITS  = $clog2(SUM_BITS);
    localparam int ADDR_BITS = apda_pkg::BAND_BITS + POS_BITS;
    localparam int DIFF_BITS =
        (SAMPLE_BITS + 3 > apda_pkg::THR_BITS + 1) ? SAMPLE_BITS + 3 : apda_pkg::THR_BITS + 1;

    logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] cur_in;
    logic [NUM_CHANNELS-1:0][2:0][SAMPLE_BITS-1:0] r_hist;
    logic [NUM_CHANNELS-1:0]                  hit;
    logic [CH_BITS-1:0]                       found;
    logic signed [DIFF_BITS-1:0]              thr_s;

    logic [apda_pkg::NUM_BANDS-1:0][SUM_BITS-1:0]    r_sum;
    logic [apda_pkg::NUM_BANDS-1:0][POS_BITS-1:0]    r_pos;
    logic [apda_pkg::NUM_BANDS-1:0][SAMPLE_BITS-1:0] r_avg;

    logic [apda_pkg::HOLD_BITS-1:0] r_hold;
    logic [apda_pkg::HOLD_BITS-1:0] n_hold;
    logic                           r_active;
    logic                           r_src_ok;
    logic [CH_BITS-1:0]             r_src;
    logic                           r_rise;
    logic                           r_fall;
    logic [SAMPLE_BITS-1:0]         r_cur;
    logic [apda_pkg::BAND_BITS-1:0] r_band;

    logic [SAMPLE_BITS-1:0] mem [(1 << ADDR_BITS)];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [POS_BITS-1:0]    r_peff;
    logic [ADDR_BITS:0]     r_clr_addr;

    logic [apda_pkg::WIN_REG_BITS-1:0] w_sel;
    logic [WIN_BITS-1:0]               w_eff;
    logic [POS_BITS-1:0]               p_eff;
    logic [WIN_BITS-1:0]               p_inc;
    logic [POS_BITS-1:0]               p_next;
    logic [SUM_BITS-1:0]               n_sum;

    logic [WIN_BITS-1:0] r_rem;
    logic [SUM_BITS-1:0] r_quo;
    logic [CNT_BITS-1:0] r_div_cnt;
    logic [WIN_BITS:0]   rem_sh;
    logic                q_bit;
    logic [SAMPLE_BITS-1:0] avg_sat;

    logic [OUT_BITS-1:0] out_word;
    logic [OUT_BITS-1:0] r_out_data;

    // detection
    always_comb begin
        thr_s = DIFF_BITS'(i_cfg.threshold);
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            logic signed [DIFF_BITS-1:0] d;
            cur_in[ch] = i_s_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS];
            d = DIFF_BITS'(cur_in[ch]) - DIFF_BITS'(r_hist[ch][0])
              + DIFF_BITS'(r_hist[ch][1]) - DIFF_BITS'(r_hist[ch][2]);
            hit[ch] = (d > thr_s) || (d < -thr_s);
        end
        found = '0;
        for (int ch = NUM_CHANNELS - 1; ch >= 0; ch--) begin
            if (hit[ch]) found = CH_BITS'(ch);
        end
    end

    assign n_hold = (r_hold != '0) ? r_hold - 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_hold   <= '0;
            r_active <= 1'b0;
            r_src_ok <= 1'b0;
            r_src    <= '0;
        end else if (i_cmd.accept) begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r_hist[ch][2] <= r_hist[ch][1];
                r_hist[ch][1] <= r_hist[ch][0];
                r_hist[ch][0] <= cur_in[ch];
            end
            if (|hit) begin
                r_active <= 1'b1;
                r_src_ok <= 1'b1;
                r_src    <= found;
                r_hold   <= i_cfg.hold;
            end else begin
                r_hold <= n_hold;
                if (n_hold == '0 && r_active) begin
                    r_active <= 1'b0;
                    r_src_ok <= 1'b0;
                    r_src    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur  <= cur_in[found];
            r_rise <= (|hit) && !r_active;
            r_fall <= !(|hit) && (n_hold == '0) && r_active;
        end
    end

    // window addressing
    always_comb begin
        w_sel = i_cfg.window[r_band];
        if (w_sel == '0) begin
            w_eff = WIN_BITS'(1);
        end else if (int'(w_sel) > MAX_WINDOW) begin
            w_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            w_eff = WIN_BITS'(w_sel);
        end
        p_eff  = (WIN_BITS'(r_pos[r_band]) >= w_eff) ? '0 : r_pos[r_band];
        p_inc  = WIN_BITS'(r_peff) + 1'b1;
        p_next = (p_inc >= w_eff) ? '0 : POS_BITS'(p_inc);
        n_sum  = r_sum[r_band] - SUM_BITS'(r_rd_data) + SUM_BITS'(r_cur);
    end

    // window store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[r_clr_addr[ADDR_BITS-1:0]] <= '0;
        end else if (i_cmd.upd) begin
            mem[r_addr] <= r_cur;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[{r_band, p_eff}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_addr <= {r_band, p_eff};
            r_peff <= p_eff;
        end
    end

    // serial divider
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_BITS-1]};
        q_bit  = (rem_sh >= {1'b0, w_eff});
        avg_sat = (r_quo > SUM_BITS'((1 << SAMPLE_BITS) - 1)) ?
                  {SAMPLE_BITS{1'b1}} : r_quo[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_rem     <= '0;
            r_quo     <= n_sum;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= q_bit ? WIN_BITS'(rem_sh - {1'b0, w_eff}) : WIN_BITS'(rem_sh);
            r_quo     <= {r_quo[SUM_BITS-2:0], q_bit};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_avg  <= '0;
            r_band <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_band <= '0;
            end
            if (i_cmd.upd) begin
                r_sum[r_band] <= n_sum;
                r_pos[r_band] <= p_next;
            end
            if (i_cmd.avg_wr) begin
                r_avg[r_band] <= avg_sat;
                r_band        <= r_band + 1'b1;
            end
        end
    end

    // result word
    always_comb begin
        out_word = '0;
        out_word[apda_pkg::OUT_ACTIVE_BIT] = r_active;
        out_word[apda_pkg::OUT_SRC_OK_BIT] = r_src_ok;
        out_word[apda_pkg::OUT_SRC_LSB +: apda_pkg::SRC_BITS] =
            r_src_ok ? apda_pkg::SRC_BITS'(r_src) : '0;
        out_word[apda_pkg::OUT_RISE_BIT] = r_rise;
        out_word[apda_pkg::OUT_FALL_BIT] = r_fall;
        for (int b = 0; b < apda_pkg::NUM_BANDS; b++) begin
            out_word[apda_pkg::OUT_AVG_LSB + b*SAMPLE_BITS +: SAMPLE_BITS] = r_avg[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= out_word;
        end
    end

    assign o_m_tdata = r_out_data;

    assign o_stat.clr_done  = r_clr_addr[ADDR_BITS];
    assign o_stat.det_hit   = |hit;
    assign o_stat.div_last  = (r_div_cnt == CNT_BITS'(SUM_BITS - 1));
    assign o_stat.last_band = (r_band == apda_pkg::BAND_BITS'(apda_pkg::NUM_BANDS - 1));

endmodule

`default_nettype wire

### rtl/audio_presence_detect_average.sv
// ----------------------------------------------------------------------------
// audio_presence_detect_average
// Audio presence detector with four running-average windows.
//
//   channel   direction  word contents
//   s         in         sample_ch0 .. sample_ch(N-1)
//   m         out        flags, source channel, four window averages
//   cfg       in         register index and write data, no read-back
//
// A word without detection skips the windows; a detecting word updates
// the four windows in turn through the one bit-serial divider they share.
// After reset a clearing pass zeroes the window store; no word is taken
// until it ends. One word is in work at a time; a finished result waits in
// the output register, and the next word is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module audio_presence_detect_average #(
    parameter int NUM_CHANNELS = 4,
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_BITS  = 10,
    localparam int IN_BITS  = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS =
        ((apda_pkg::OUT_AVG_LSB + apda_pkg::NUM_BANDS * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // sample_ch0, sample_ch1, ... each SAMPLE_BITS wide, zero padded
    input  wire  [IN_BITS-1:0]                  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // audio_active, source_valid, source_channel[1:0], went_active,
    // went_inactive, average_a, average_b, average_c, average_d, zero padded
    output logic [OUT_BITS-1:0]                 o_m_tdata,
    input  wire                                 i_cfg_wr_en,
    input  wire  [apda_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire  [apda_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    apda_pkg::t_cfg  cfg;
    apda_pkg::t_cmd  cmd;
    apda_pkg::t_stat stat;

    logic out_active;
    logic out_src_ok;
    logic out_rise;
    logic out_fall;

    apda_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    apda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    apda_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_s_tdata (i_s_tdata),
        .o_m_tdata (o_m_tdata)
    );

    assign out_active = o_m_tdata[apda_pkg::OUT_ACTIVE_BIT];
    assign out_src_ok = o_m_tdata[apda_pkg::OUT_SRC_OK_BIT];
    assign out_rise   = o_m_tdata[apda_pkg::OUT_RISE_BIT];
    assign out_fall   = o_m_tdata[apda_pkg::OUT_FALL_BIT];

    `ASSERT_HOLDS(a_src_follows_active, i_clk, i_rst_n, !o_m_tvalid || (out_active == out_src_ok))
    `ASSERT_HOLDS(a_rise_is_active, i_clk, i_rst_n, !(o_m_tvalid && out_rise) || out_active)
    `ASSERT_HOLDS(a_fall_is_idle, i_clk, i_rst_n, !(o_m_tvalid && out_fall) || !out_active)
    `ASSERT_NEXT(a_one_word_in_work, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

`default_nettype wire
